// ===== src/point_polyline_min_sq_distance_defines.svh =====
// Assertion macros shared by the point to polyline distance block.
// Uses the clk and arst_n names of the module that includes it.
`ifndef POINT_POLYLINE_MIN_SQ_DISTANCE_DEFINES_SVH
`define POINT_POLYLINE_MIN_SQ_DISTANCE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PPD_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ppd same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define PPD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ppd next-cycle check failed");

`endif

// ===== src/ppd_pkg.sv =====
// Constants and codes for the point to polyline distance block.
// No dependencies.
package ppd_pkg;
	localparam int MAX_POINTS = 256;
	localparam int COORD_BITS = 20;
	localparam int AW = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int DW = COORD_BITS + 1;
	localparam int SQ_W = 2 * DW;
	localparam int DOT_W = SQ_W + 1;
	localparam int DIST_W = 44;
	localparam int DC_W = $clog2(SQ_W);

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_ANSWER = 2'd2;
	localparam logic [1:0] ST_NOSEG = 2'd3;
endpackage

// ===== src/point_polyline_min_sq_distance.sv =====
// Top level of the point to polyline least squared distance block.
// Depends on ppd_pkg, ppd_ram and point_polyline_min_sq_distance_defines.svh.
// The main work of a query is a 42-step radix-2 division of dot^2 by the segment length, done for
// each segment whose projection falls strictly inside it; the products come from one shared 21 by
// 21 multiplier and the division from one compare-subtract unit.
`include "point_polyline_min_sq_distance_defines.svh"
module point_polyline_min_sq_distance
	import ppd_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [1:0]             operation,
	input  logic [COORD_BITS-1:0]  coord_x,
	input  logic [COORD_BITS-1:0]  coord_y,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [1:0]             status,
	output logic [DIST_W-1:0]      sq_distance,
	output logic [CNT_W-1:0]       vertex_count
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_L1 = 4'd1;
	localparam logic [3:0] S_L2 = 4'd2;
	localparam logic [3:0] S_QA = 4'd3;
	localparam logic [3:0] S_QB = 4'd4;
	localparam logic [3:0] S_QC = 4'd5;
	localparam logic [3:0] S_M1 = 4'd6;
	localparam logic [3:0] S_M2 = 4'd7;
	localparam logic [3:0] S_M3 = 4'd8;
	localparam logic [3:0] S_M4 = 4'd9;
	localparam logic [3:0] S_M5 = 4'd10;
	localparam logic [3:0] S_M6 = 4'd11;
	localparam logic [3:0] S_DEC = 4'd12;
	localparam logic [3:0] S_DIV = 4'd13;
	localparam logic [3:0] S_UPD = 4'd14;
	localparam logic [3:0] S_QN = 4'd15;

	logic [3:0] state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] seg_q;
	logic signed [COORD_BITS-1:0] px_q, py_q, lx_q, ly_q, sx_q, sy_q, ex_q, ey_q;
	logic signed [DOT_W-1:0] dot_q;
	logic [SQ_W-1:0] v2_q, end_q, len_q, acc_q, quo_q, cand_q, best_q;
	logic [DC_W-1:0] dcnt_q;
	logic have_q;
	logic out_valid_q;
	logic [1:0] status_q;
	logic [DIST_W-1:0] dist_q;

	logic accept;
	logic signed [DW-1:0] ma, mb;
	logic signed [SQ_W-1:0] prod;
	logic [SQ_W-1:0] prod_u;
	logic [SQ_W+1:0] dv_t, dv_n, dv_2n;
	logic [SQ_W-1:0] dv_r;
	logic [1:0] dv_d;
	logic is_last;

	logic x_we, y_we, len_we;
	logic [AW-1:0] v_waddr, v_raddr, len_waddr, len_raddr;
	logic [COORD_BITS-1:0] x_rdata, y_rdata;
	logic [SQ_W-1:0] len_rdata, len_wdata;

	assign in_stall = (state_q != S_IDLE) || out_valid_q;
	assign accept = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign status = status_q;
	assign sq_distance = dist_q;
	assign vertex_count = cnt_q;
	assign is_last = (seg_q + CNT_W'(2)) == cnt_q;

	function automatic logic signed [DW-1:0] diff(input logic signed [COORD_BITS-1:0] a,
		input logic signed [COORD_BITS-1:0] b);
		diff = DW'(a) - DW'(b);
	endfunction

	always_comb begin
		ma = '0;
		mb = '0;
		case (state_q)
			S_L1: begin
				ma = diff(px_q, lx_q);
				mb = ma;
			end
			S_L2: begin
				ma = diff(py_q, ly_q);
				mb = ma;
			end
			S_M1: begin
				ma = diff(ex_q, sx_q);
				mb = diff(px_q, sx_q);
			end
			S_M2: begin
				ma = diff(ey_q, sy_q);
				mb = diff(py_q, sy_q);
			end
			S_M3: begin
				ma = diff(px_q, sx_q);
				mb = ma;
			end
			S_M4: begin
				ma = diff(py_q, sy_q);
				mb = ma;
			end
			S_M5: begin
				ma = diff(px_q, ex_q);
				mb = ma;
			end
			S_M6: begin
				ma = diff(py_q, ey_q);
				mb = ma;
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	assign prod = SQ_W'(ma) * SQ_W'(mb);
	assign prod_u = $unsigned(prod);

	always_comb begin
		dv_n = {2'b00, len_q};
		dv_2n = {1'b0, len_q, 1'b0};
		dv_t = {1'b0, acc_q, 1'b0} + (dot_q[dcnt_q] ? {2'b00, dot_q[SQ_W-1:0]} : '0);
		if (dv_t >= dv_2n) begin
			dv_r = SQ_W'(dv_t - dv_2n);
			dv_d = 2'd2;
		end else if (dv_t >= dv_n) begin
			dv_r = SQ_W'(dv_t - dv_n);
			dv_d = 2'd1;
		end else begin
			dv_r = SQ_W'(dv_t);
			dv_d = 2'd0;
		end
	end

	assign x_we = accept && (operation == OP_APPEND) && (cnt_q < CNT_W'(MAX_POINTS));
	assign y_we = x_we;
	assign v_waddr = cnt_q[AW-1:0];
	assign len_we = (state_q == S_L2);
	assign len_waddr = AW'(cnt_q - CNT_W'(1));
	assign len_wdata = acc_q + prod_u;
	assign v_raddr = (state_q == S_QA) ? '0 : AW'(seg_q + CNT_W'(1));
	assign len_raddr = seg_q[AW-1:0];

	ppd_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_POINTS)) u_x_ram (
		.clk(clk), .we(x_we), .waddr(v_waddr), .wdata(coord_x),
		.raddr(v_raddr), .rdata(x_rdata)
	);

	ppd_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_POINTS)) u_y_ram (
		.clk(clk), .we(y_we), .waddr(v_waddr), .wdata(coord_y),
		.raddr(v_raddr), .rdata(y_rdata)
	);

	ppd_ram #(.WIDTH(SQ_W), .DEPTH(MAX_POINTS - 1)) u_len_ram (
		.clk(clk), .we(len_we), .waddr(len_waddr), .wdata(len_wdata),
		.raddr(len_raddr), .rdata(len_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
			have_q <= 1'b0;
			seg_q <= '0;
			dcnt_q <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						px_q <= coord_x;
						py_q <= coord_y;
						status_q <= ST_DONE;
						dist_q <= '0;
						case (operation)
							OP_CLEAR: begin
								cnt_q <= '0;
								out_valid_q <= 1'b1;
							end
							OP_APPEND: begin
								if (cnt_q >= CNT_W'(MAX_POINTS)) begin
									status_q <= ST_FULL;
									out_valid_q <= 1'b1;
								end else if (cnt_q == '0) begin
									lx_q <= coord_x;
									ly_q <= coord_y;
									cnt_q <= CNT_W'(1);
									out_valid_q <= 1'b1;
								end else begin
									state_q <= S_L1;
								end
							end
							OP_QUERY: begin
								if (cnt_q < CNT_W'(2)) begin
									status_q <= ST_NOSEG;
									out_valid_q <= 1'b1;
								end else begin
									seg_q <= '0;
									have_q <= 1'b0;
									state_q <= S_QA;
								end
							end
							default: begin
								out_valid_q <= 1'b1;
							end
						endcase
					end
				end
				S_L1: begin
					acc_q <= prod_u;
					state_q <= S_L2;
				end
				S_L2: begin
					lx_q <= px_q;
					ly_q <= py_q;
					cnt_q <= cnt_q + CNT_W'(1);
					out_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				S_QA: begin
					state_q <= S_QB;
				end
				S_QB: begin
					sx_q <= x_rdata;
					sy_q <= y_rdata;
					state_q <= S_QC;
				end
				S_QN: begin
					state_q <= S_QC;
				end
				S_QC: begin
					ex_q <= x_rdata;
					ey_q <= y_rdata;
					len_q <= len_rdata;
					state_q <= S_M1;
				end
				S_M1: begin
					dot_q <= DOT_W'(prod);
					state_q <= S_M2;
				end
				S_M2: begin
					dot_q <= dot_q + DOT_W'(prod);
					state_q <= S_M3;
				end
				S_M3: begin
					v2_q <= prod_u;
					state_q <= S_M4;
				end
				S_M4: begin
					v2_q <= v2_q + prod_u;
					state_q <= S_M5;
				end
				S_M5: begin
					end_q <= prod_u;
					state_q <= S_M6;
				end
				S_M6: begin
					end_q <= end_q + prod_u;
					state_q <= S_DEC;
				end
				S_DEC: begin
					if (dot_q[DOT_W-1] || (dot_q == '0)) begin
						cand_q <= v2_q;
						state_q <= S_UPD;
					end else if (dot_q[SQ_W-1:0] >= len_q) begin
						if (is_last) begin
							cand_q <= end_q;
							state_q <= S_UPD;
						end else begin
							seg_q <= seg_q + CNT_W'(1);
							sx_q <= ex_q;
							sy_q <= ey_q;
							state_q <= S_QN;
						end
					end else begin
						acc_q <= '0;
						quo_q <= '0;
						dcnt_q <= DC_W'(SQ_W - 1);
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					acc_q <= dv_r;
					quo_q <= {quo_q[SQ_W-2:0], 1'b0} + SQ_W'(dv_d);
					if (dcnt_q == '0) begin
						cand_q <= v2_q - ({quo_q[SQ_W-2:0], 1'b0} + SQ_W'(dv_d));
						state_q <= S_UPD;
					end else begin
						dcnt_q <= dcnt_q - DC_W'(1);
					end
				end
				S_UPD: begin
					if (is_last) begin
						status_q <= ST_ANSWER;
						dist_q <= DIST_W'((!have_q || cand_q < best_q) ? cand_q : best_q);
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						seg_q <= seg_q + CNT_W'(1);
						sx_q <= ex_q;
						sy_q <= ey_q;
						state_q <= S_QN;
					end
					if (!have_q || cand_q < best_q) begin
						best_q <= cand_q;
					end
					have_q <= 1'b1;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`PPD_ASSERT_NOW(a_busy_stalls, state_q != S_IDLE, in_stall)
	`PPD_ASSERT_NOW(a_count_bound, 1'b1, cnt_q <= CNT_W'(MAX_POINTS))
	`PPD_ASSERT_NOW(a_div_range, state_q == S_DIV, !dot_q[DOT_W-1] && dot_q[SQ_W-1:0] < len_q)
	`PPD_ASSERT_NOW(a_dist_zero, out_valid_q && status_q != ST_ANSWER, dist_q == '0)
	`PPD_ASSERT_NEXT(a_query_busy, accept && operation == OP_QUERY && cnt_q >= CNT_W'(2),
		state_q == S_QA)
endmodule

// ===== src/ppd_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module ppd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== test/tb_point_polyline_min_sq_distance.sv =====
// Testbench for point_polyline_min_sq_distance: drives clear, append and query beats
// with random gaps and stalls, and checks every result against a built-in polyline model.
// Depends on ppd_pkg and the block's RTL.
`timescale 1ns / 1ps
module tb_point_polyline_min_sq_distance;
	import ppd_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 6000000;

	class polyline_scoreboard;
		typedef struct {
			logic [1:0]        st;
			logic [DIST_W-1:0] sqd;
			logic [CNT_W-1:0]  cnt;
		} result_t;

		result_t expected[$];
		longint vx[MAX_POINTS];
		longint vy[MAX_POINTS];
		longint seg_len2[MAX_POINTS];
		int held;
		int errors;

		function new();
			held = 0;
			errors = 0;
		endfunction

		function longint distance_to(longint px, longint py, int i, int segs, output bit used);
			longint v2x, v2y, dot, sq;
			logic [127:0] dd, quot;
			v2x = px - vx[i];
			v2y = py - vy[i];
			dot = (vx[i+1] - vx[i]) * v2x + (vy[i+1] - vy[i]) * v2y;
			sq = v2x * v2x + v2y * v2y;
			used = 1;
			if (dot <= 0) begin
				return sq;
			end else if (dot >= seg_len2[i]) begin
				used = (i + 1 == segs);
				return (px - vx[i+1]) * (px - vx[i+1]) + (py - vy[i+1]) * (py - vy[i+1]);
			end
			dd = 128'(dot);
			quot = (dd * dd) / 128'(seg_len2[i]);
			return sq - longint'(quot[63:0]);
		endfunction

		function void note_input(logic [1:0] op, logic [COORD_BITS-1:0] x,
				logic [COORD_BITS-1:0] y);
			result_t r;
			longint px, py, d, best;
			bit used, have;
			px = longint'($signed(x));
			py = longint'($signed(y));
			r.st = ST_DONE;
			r.sqd = '0;
			if (op == OP_CLEAR) begin
				held = 0;
			end else if (op == OP_APPEND) begin
				if (held >= MAX_POINTS) begin
					r.st = ST_FULL;
				end else begin
					vx[held] = px;
					vy[held] = py;
					if (held > 0)
						seg_len2[held-1] = (px - vx[held-1]) * (px - vx[held-1])
							+ (py - vy[held-1]) * (py - vy[held-1]);
					held++;
				end
			end else if (op == OP_QUERY) begin
				if (held < 2) begin
					r.st = ST_NOSEG;
				end else begin
					have = 0;
					best = 0;
					for (int i = 0; i < held - 1; i++) begin
						d = distance_to(px, py, i, held - 1, used);
						if (used && (!have || d < best)) begin
							best = d;
							have = 1;
						end
					end
					r.st = ST_ANSWER;
					r.sqd = DIST_W'(best);
				end
			end
			r.cnt = CNT_W'(held);
			expected = {expected, r};
		endfunction

		task report(string msg);
			errors++;
			$display("mismatch: %s", msg);
		endtask

		task check_result(logic [1:0] st, logic [DIST_W-1:0] sqd, logic [CNT_W-1:0] cnt);
			result_t r;
			if (expected.size() == 0) begin
				report($sformatf("unexpected result status %0d", st));
			end else begin
				r = expected.pop_front();
				if (st !== r.st)
					report($sformatf("status %0d, expected %0d", st, r.st));
				if (sqd !== r.sqd)
					report($sformatf("sq_distance %0d, expected %0d", sqd, r.sqd));
				if (cnt !== r.cnt)
					report($sformatf("vertex_count %0d, expected %0d", cnt, r.cnt));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] operation = OP_CLEAR;
	logic [COORD_BITS-1:0] coord_x = '0;
	logic [COORD_BITS-1:0] coord_y = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] status;
	logic [DIST_W-1:0] sq_distance;
	logic [CNT_W-1:0] vertex_count;

	polyline_scoreboard sb = new();
	bit quiet = 0;
	bit hold_request = 0;
	bit hold_rx = 0;
	int rx_wait = 0;
	int cycles = 0;
	int sent = 0;

	point_polyline_min_sq_distance dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .coord_x(coord_x), .coord_y(coord_y),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .sq_distance(sq_distance), .vertex_count(vertex_count)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("** point_polyline_min_sq_distance: FAILED **");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			sb.check_result(status, sq_distance, vertex_count);
			rx_wait = quiet ? 0 : $urandom_range(0, 4);
		end
		if (rx_wait > 0 && !hold_rx) rx_wait--;
		out_stall <= hold_rx || (rx_wait > 0);
	end

	initial begin
		wait (hold_request);
		@(posedge clk);
		hold_rx = 1;
		repeat (600) @(posedge clk);
		hold_rx = 0;
	end

	task send(logic [1:0] op, logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		coord_x <= x;
		coord_y <= y;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_input(op, x, y);
		sent++;
	endtask

	function logic [COORD_BITS-1:0] rand_coord();
		case ($urandom_range(0, 5))
			0, 1: return COORD_BITS'($urandom);
			2, 3: return COORD_BITS'($signed($urandom_range(0, 100)) - 50);
			4: return COORD_BITS'($signed($urandom_range(0, 4000)) - 2000);
			default: return $urandom_range(0, 1) ? {1'b1, {(COORD_BITS-1){1'b0}}}
				: {1'b0, {(COORD_BITS-1){1'b1}}};
		endcase
	endfunction

	localparam logic [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};
	localparam logic [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};

	initial begin
		int nv, nq;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(OP_CLEAR, '0, '0);
		send(OP_QUERY, 20'd5, 20'd5);
		send(OP_APPEND, '0, '0);
		send(OP_QUERY, 20'd3, 20'd4);
		send(OP_APPEND, '0, '0);
		send(OP_QUERY, 20'd3, 20'd4);
		send(OP_CLEAR, CMAX, CMIN);
		send(OP_APPEND, CMIN, CMIN);
		send(OP_APPEND, CMAX, CMAX);
		send(OP_QUERY, CMAX, CMIN);
		send(OP_QUERY, CMIN, CMAX);
		send(OP_QUERY, CMAX, CMAX);
		send(OP_QUERY, CMIN, CMIN);
		send(OP_APPEND, CMAX, CMIN);
		send(OP_QUERY, CMAX, CMAX);
		send(OP_QUERY, CMIN, CMAX);
		send(OP_QUERY, 20'd7, -20'sd9);
		send(OP_UNUSED, CMAX, CMIN);
		send(OP_QUERY, CMAX, 20'd0);

		while (sent < 1950) begin
			if (sent > 500 && !hold_request) hold_request = 1;
			quiet = (sent > 1200 && sent < 1400);
			if (sent > 1000 && sent < 1030) begin
				in_valid <= 1'b0;
				while (sb.expected.size() != 0) @(posedge clk);
			end
			if ($urandom_range(0, 150) == 0) begin
				send(OP_CLEAR, rand_coord(), rand_coord());
				for (int i = 0; i < MAX_POINTS + 2; i++)
					send(OP_APPEND, rand_coord(), rand_coord());
				send(OP_QUERY, rand_coord(), rand_coord());
			end else begin
				if ($urandom_range(0, 3) != 0) send(OP_CLEAR, rand_coord(), rand_coord());
				nv = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 8);
				for (int i = 0; i < nv; i++) send(OP_APPEND, rand_coord(), rand_coord());
				nq = $urandom_range(1, 5);
				for (int i = 0; i < nq; i++) begin
					case ($urandom_range(0, 9))
						0: send(OP_UNUSED, rand_coord(), rand_coord());
						1: send(OP_APPEND, rand_coord(), rand_coord());
						default: send(OP_QUERY, rand_coord(), rand_coord());
					endcase
				end
			end
		end
		in_valid <= 1'b0;
		quiet = 0;

		while (sb.expected.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.errors == 0)
			$display("** point_polyline_min_sq_distance: PASSED **");
		else
			$display("** point_polyline_min_sq_distance: FAILED **");
		$finish;
	end
endmodule

// ===== point_polyline_min_sq_distance.f =====
+incdir+src
src/ppd_pkg.sv
src/ppd_ram.sv
src/point_polyline_min_sq_distance.sv
test/tb_point_polyline_min_sq_distance.sv
